FILE: rtl/core/rc4_stream_cipher_assert.svh
// assertion helpers shared by the cipher core
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// property checked at every clock edge outside reset
`define RC4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define RC4_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/rc4_pkg.sv
package rc4_pkg;

  localparam int BYTE_W       = 8;
  localparam int SBOX_DEPTH   = 256;
  localparam int SBOX_AW      = 8;
  localparam int KEY_BYTES_DF = 256;
  localparam int KLEN_W       = 9;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_CRYPT = 2'd2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

endpackage

FILE: rtl/core/rc4_ram.sv
module rc4_ram #(
  parameter int DEPTH = rc4_pkg::SBOX_DEPTH,
  parameter int AW    = rc4_pkg::SBOX_AW
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rc4_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [rc4_pkg::BYTE_W-1:0] rd_data
);

  logic [rc4_pkg::BYTE_W-1:0] mem_r [DEPTH];
  logic [rc4_pkg::BYTE_W-1:0] rd_data_r;

  // read returns the old word when read and write hit the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/rc4_stream_cipher.sv
// rc4 engine around one 256x8 s-box memory (1 write + 1 registered read port) and a key store.
// load key byte: written to the key store while idle, busy stays low, no result word.
// crypt byte: busy in read-j, swap and output, then a result strobe; one byte at a time.
// key schedule: busy through 256 identity writes, then 4 s-box accesses per swap step.
// sync reset clears the i/j indices, key_length (to 16) and control; memories hold garbage until written.
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher #(
  parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_key_index,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_strobe,
  output logic [7:0]                    out_result_byte,
  output logic                          out_result_kind,
  input  logic                          cfg_wr_en,
  input  logic [rc4_pkg::KLEN_W-1:0]    cfg_wr_data
);

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KW     = rc4_pkg::KLEN_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_K_INIT = 4'd1;
  localparam logic [3:0] ST_K_RDN  = 4'd2;
  localparam logic [3:0] ST_K_RDA  = 4'd3;
  localparam logic [3:0] ST_K_WRN  = 4'd4;
  localparam logic [3:0] ST_K_WRA  = 4'd5;
  localparam logic [3:0] ST_C_RDJ  = 4'd6;
  localparam logic [3:0] ST_C_SWP  = 4'd7;
  localparam logic [3:0] ST_C_OUT  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [7:0]        n_r, n_nxt;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;
  logic [7:0]        gen_i_r, gen_i_nxt;
  logic [7:0]        gen_j_r, gen_j_nxt;
  logic [7:0]        sa_r, sa_nxt;
  logic [7:0]        sb_r, sb_nxt;
  logic [7:0]        t_r, t_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [KW-1:0]     key_length_r;
  logic              out_strobe_r, out_strobe_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_kind_r, out_kind_nxt;

  logic              sbox_we;
  logic [7:0]        sbox_wa, sbox_wd, sbox_ra, sbox_rd;
  logic              key_we;
  logic [KIDX_W-1:0] key_wa, key_ra;
  logic [7:0]        key_rd;

  logic [KW-1:0]     len_used, len_last;
  logic [7:0]        sum8, ks;

  // zero or oversized length means the full 256, then bounded by the store
  always_comb begin
    len_used = key_length_r;
    if ((key_length_r == '0) || (key_length_r > KW'(256))) begin
      len_used = KW'(256);
    end
    if (len_used > KW'(KEY_BYTES)) begin
      len_used = KW'(KEY_BYTES);
    end
    len_last = len_used - KW'(1);
  end

  rc4_ram #(
    .DEPTH (rc4_pkg::SBOX_DEPTH),
    .AW    (rc4_pkg::SBOX_AW)
  ) u_sbox (
    .clk     (clk),
    .wr_en   (sbox_we),
    .wr_addr (sbox_wa),
    .wr_data (sbox_wd),
    .rd_addr (sbox_ra),
    .rd_data (sbox_rd)
  );

  rc4_ram #(
    .DEPTH (KEY_BYTES),
    .AW    (KIDX_W)
  ) u_key (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_wa),
    .wr_data (in_data_byte),
    .rd_addr (key_ra),
    .rd_data (key_rd)
  );

  assign key_wa = in_key_index[KIDX_W-1:0];
  assign key_ra = kidx_r;
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    kidx_nxt       = kidx_r;
    gen_i_nxt      = gen_i_r;
    gen_j_nxt      = gen_j_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    t_nxt          = t_r;
    data_nxt       = data_r;
    out_strobe_nxt = 1'b0;
    out_byte_nxt   = out_byte_r;
    out_kind_nxt   = out_kind_r;
    sbox_we        = 1'b0;
    sbox_wa        = n_r;
    sbox_wd        = n_r;
    sbox_ra        = n_r;
    key_we         = 1'b0;
    sum8           = '0;
    ks             = sbox_rd;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_command)
            rc4_pkg::CMD_LOAD: begin
              key_we = ({1'b0, in_key_index} < KW'(KEY_BYTES));
            end
            rc4_pkg::CMD_SCHED: begin
              n_nxt     = '0;
              state_nxt = ST_K_INIT;
            end
            rc4_pkg::CMD_CRYPT: begin
              // s[i+1] is fetched right at the accept edge
              gen_i_nxt = gen_i_r + 8'd1;
              sbox_ra   = gen_i_r + 8'd1;
              data_nxt  = in_data_byte;
              state_nxt = ST_C_RDJ;
            end
            default: ;
          endcase
        end
      end
      ST_K_INIT: begin
        sbox_we = 1'b1;
        n_nxt   = n_r + 8'd1;
        if (n_r == 8'hFF) begin
          gen_j_nxt = '0;
          kidx_nxt  = '0;
          state_nxt = ST_K_RDN;
        end
      end
      ST_K_RDN: begin
        state_nxt = ST_K_RDA;
      end
      ST_K_RDA: begin
        // gen_j doubles as the schedule accumulator
        sum8      = gen_j_r + sbox_rd + key_rd;
        gen_j_nxt = sum8;
        sa_nxt    = sbox_rd;
        sbox_ra   = sum8;
        state_nxt = ST_K_WRN;
      end
      ST_K_WRN: begin
        sbox_we   = 1'b1;
        sbox_wd   = sbox_rd;
        state_nxt = ST_K_WRA;
      end
      ST_K_WRA: begin
        sbox_we  = 1'b1;
        sbox_wa  = gen_j_r;
        sbox_wd  = sa_r;
        n_nxt    = n_r + 8'd1;
        kidx_nxt = (KW'(kidx_r) == len_last) ? '0 : kidx_r + KIDX_W'(1);
        if (n_r == 8'hFF) begin
          gen_i_nxt      = '0;
          gen_j_nxt      = '0;
          out_strobe_nxt = 1'b1;
          out_byte_nxt   = '0;
          out_kind_nxt   = rc4_pkg::KIND_DONE;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_K_RDN;
        end
      end
      ST_C_RDJ: begin
        sum8      = gen_j_r + sbox_rd;
        gen_j_nxt = sum8;
        sa_nxt    = sbox_rd;
        sbox_ra   = sum8;
        state_nxt = ST_C_SWP;
      end
      ST_C_SWP: begin
        sbox_we   = 1'b1;
        sbox_wa   = gen_i_r;
        sbox_wd   = sbox_rd;
        sb_nxt    = sbox_rd;
        sum8      = sa_r + sbox_rd;
        t_nxt     = sum8;
        sbox_ra   = sum8;
        state_nxt = ST_C_OUT;
      end
      ST_C_OUT: begin
        sbox_we = 1'b1;
        sbox_wa = gen_j_r;
        sbox_wd = sa_r;
        // the read of s[t] raced the swap writes, take the new word on a hit
        if (t_r == gen_j_r) begin
          ks = sa_r;
        end else if (t_r == gen_i_r) begin
          ks = sb_r;
        end
        out_strobe_nxt = 1'b1;
        out_byte_nxt   = data_r ^ ks;
        out_kind_nxt   = rc4_pkg::KIND_DATA;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gen_i_r      <= '0;
      gen_j_r      <= '0;
      key_length_r <= rc4_pkg::KLEN_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gen_i_r      <= gen_i_nxt;
      gen_j_r      <= gen_j_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        key_length_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    kidx_r     <= kidx_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_byte = out_byte_r;
  assign out_result_kind = out_kind_r;

  `RC4_ASSERT(a_strobe_when_idle, out_strobe_r |-> (state_r == ST_IDLE), "result word while busy")
  `RC4_ASSERT_NEXT(a_strobe_after_finish, (state_r == ST_C_OUT) || ((state_r == ST_K_WRA) && (n_r == 8'hFF)), out_strobe_r, "finished item gave no result word")
  `RC4_ASSERT(a_done_clears_idx, (out_strobe_r && (out_kind_r == rc4_pkg::KIND_DONE)) |-> ((gen_i_r == 8'd0) && (gen_j_r == 8'd0)), "schedule done with live indices")
  `RC4_ASSERT(a_key_write_idle, key_we |-> (state_r == ST_IDLE), "key store written while busy")

endmodule
